// File: design/bdp_pkg.sv
// Shared constants and floating-point helpers for the BF16 dot-product block.
`timescale 1ns / 1ps
package bdp_pkg;

   localparam logic [31:0] QNAN = 32'h7FC0_0000;
   localparam logic [31:0] POS_ZERO = 32'h0000_0000;

   function automatic logic [4:0] lzc28(input logic [27:0] v);
      logic [4:0] n;
      n = 5'd0;
      for (int i = 0; i < 28; i++) begin
         if (v[i]) begin
            n = 5'(27 - i);
         end
      end
      return n;
   endfunction

   // sig has its leading one at bit 27, value = sig / 2^27 * 2^(exp - 127)
   function automatic logic [31:0] round_pack(input logic sign, input logic signed [9:0] exp,
                                              input logic [27:0] sig);
      logic [10:0] sh;
      logic [4:0]  cap;
      logic [27:0] sig_s;
      logic        lost;
      logic [7:0]  ef;
      logic [30:0] body;
      logic        inc;
      sh = 11'd0;
      cap = 5'd0;
      if (exp >= 10'sd255) begin
         return {sign, 8'hFF, 23'd0};
      end
      if (exp <= 10'sd0) begin
         sh = 11'd1 - {exp[9], exp};
         cap = (sh > 11'd28) ? 5'd28 : sh[4:0];
         sig_s = sig >> cap;
         lost = |(sig & ~(28'hFFF_FFFF << cap));
         ef = 8'd0;
      end else begin
         sig_s = sig;
         lost = 1'b0;
         ef = exp[7:0];
      end
      body = {ef, sig_s[26:4]};
      inc = sig_s[3] & ((|sig_s[2:0]) | lost | sig_s[4]);
      body = body + 31'(inc);
      return {sign, body};
   endfunction

endpackage

// File: design/bdp_mul.sv
// BF16 by BF16 multiplier rounded to FP32.
`timescale 1ns / 1ps
module bdp_mul (
   input  logic [15:0] a_value,
   input  logic [15:0] b_value,
   output logic [31:0] prod_value
);

   logic              a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
   logic [7:0]        sa, sb;
   logic signed [9:0] ea, eb, ep;
   logic [2:0]        lza, lzb;
   logic [15:0]       sp;
   logic [27:0]       sig;
   logic              sign;

   always_comb begin
      a_nan  = (a_value[14:7] == 8'hFF) && (a_value[6:0] != 7'd0);
      a_inf  = (a_value[14:7] == 8'hFF) && (a_value[6:0] == 7'd0);
      a_zero = (a_value[14:7] == 8'h00) && (a_value[6:0] == 7'd0);
      b_nan  = (b_value[14:7] == 8'hFF) && (b_value[6:0] != 7'd0);
      b_inf  = (b_value[14:7] == 8'hFF) && (b_value[6:0] == 7'd0);
      b_zero = (b_value[14:7] == 8'h00) && (b_value[6:0] == 7'd0);
      sign = a_value[15] ^ b_value[15];
      lza = 3'd0;
      lzb = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (i < 7 && a_value[i]) begin
            lza = 3'(7 - i);
         end
         if (i < 7 && b_value[i]) begin
            lzb = 3'(7 - i);
         end
      end
      if (a_value[14:7] != 8'h00) begin
         sa = {1'b1, a_value[6:0]};
         ea = {2'b00, a_value[14:7]};
      end else begin
         sa = {1'b0, a_value[6:0]} << lza;
         ea = 10'sd1 - {7'd0, lza};
      end
      if (b_value[14:7] != 8'h00) begin
         sb = {1'b1, b_value[6:0]};
         eb = {2'b00, b_value[14:7]};
      end else begin
         sb = {1'b0, b_value[6:0]} << lzb;
         eb = 10'sd1 - {7'd0, lzb};
      end
      sp = sa * sb;
      if (sp[15]) begin
         sig = {sp, 12'd0};
         ep = ea + eb - 10'sd126;
      end else begin
         sig = {sp[14:0], 13'd0};
         ep = ea + eb - 10'sd127;
      end
      if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
         prod_value = bdp_pkg::QNAN;
      end else if (a_inf || b_inf) begin
         prod_value = {sign, 8'hFF, 23'd0};
      end else if (a_zero || b_zero) begin
         prod_value = {sign, 31'd0};
      end else begin
         prod_value = bdp_pkg::round_pack(sign, ep, sig);
      end
   end

endmodule

// File: design/bdp_add.sv
// FP32 adder with round-to-nearest-even, subnormals kept, NaN made canonical.
`timescale 1ns / 1ps
module bdp_add (
   input  logic [31:0] x_value,
   input  logic [31:0] y_value,
   output logic [31:0] sum_value
);

   logic              x_nan, y_nan, x_inf, y_inf, swap, eff_sub;
   logic [31:0]       big, sml;
   logic [7:0]        eb, es, d;
   logic [26:0]       big27, sml27, shifted;
   logic              sticky;
   logic [27:0]       res, norm;
   logic [4:0]        lz;
   logic signed [9:0] exp;

   always_comb begin
      x_nan = (x_value[30:23] == 8'hFF) && (x_value[22:0] != 23'd0);
      y_nan = (y_value[30:23] == 8'hFF) && (y_value[22:0] != 23'd0);
      x_inf = (x_value[30:23] == 8'hFF) && (x_value[22:0] == 23'd0);
      y_inf = (y_value[30:23] == 8'hFF) && (y_value[22:0] == 23'd0);
      swap = y_value[30:0] > x_value[30:0];
      big = swap ? y_value : x_value;
      sml = swap ? x_value : y_value;
      eff_sub = big[31] ^ sml[31];
      eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      d = eb - es;
      big27 = {(big[30:23] != 8'd0), big[22:0], 3'd0};
      sml27 = {(sml[30:23] != 8'd0), sml[22:0], 3'd0};
      if (d >= 8'd27) begin
         shifted = 27'd0;
         sticky = |sml27;
      end else begin
         shifted = sml27 >> d;
         sticky = |(sml27 & ~(27'h7FF_FFFF << d));
      end
      shifted = {shifted[26:1], shifted[0] | sticky};
      res = eff_sub ? ({1'b0, big27} - {1'b0, shifted}) : ({1'b0, big27} + {1'b0, shifted});
      lz = bdp_pkg::lzc28(res);
      norm = res << lz;
      exp = {2'b00, eb} + 10'sd1 - {5'd0, lz};
      if (x_nan || y_nan || (x_inf && y_inf && (x_value[31] != y_value[31]))) begin
         sum_value = bdp_pkg::QNAN;
      end else if (x_inf || y_inf) begin
         sum_value = {big[31], 8'hFF, 23'd0};
      end else if (x_value[30:0] == 31'd0 && y_value[30:0] == 31'd0) begin
         sum_value = {x_value[31] & y_value[31], 31'd0};
      end else if (res == 28'd0) begin
         sum_value = bdp_pkg::POS_ZERO;
      end else begin
         sum_value = bdp_pkg::round_pack(big[31], exp, norm);
      end
   end

endmodule

// File: design/bf16_dot_product_fp32_accumulate_top.sv
// Top level of the BF16 dot-product engine with FP32 accumulation.
// Takes one BF16 pair per cycle while not stalled and keeps an FP32 running sum: the first
// request of a dot product seeds the sum with its bias, every request adds its own rounded
// product, and the last request emits the sum. The result passes through the s1, s2 and
// response registers after its last request is accepted; one request per cycle is sustained
// while not stalled, bounded by the combinational FP32 add in the accumulate feedback.
// The pipeline stalls only during reset or while a finished result waits on a stalled output.
`timescale 1ns / 1ps
module bf16_dot_product_fp32_accumulate_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_a_value,
   input  logic [15:0] req_b_value,
   input  logic [31:0] req_bias_value,
   input  logic        req_first_item,
   input  logic        req_last_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_sum_value
);

   logic        adv;
   logic        s1_valid_ff, s1_first_ff, s1_last_ff;
   logic [15:0] s1_a_ff, s1_b_ff;
   logic [31:0] s1_bias_ff;
   logic        s2_valid_ff, s2_first_ff, s2_last_ff;
   logic [31:0] s2_bias_ff, s2_prod_ff;
   logic [31:0] prod_in, acc_op, sum_in;
   logic [31:0] sum_ff, rsp_sum_ff;
   logic        rsp_valid_ff;

   assign adv = !(rsp_valid_ff && rsp_stall);
   assign req_stall = reset || !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sum_value = rsp_sum_ff;
   assign acc_op = s2_first_ff ? s2_bias_ff : sum_ff;

   bdp_mul u_mul (
      .a_value    (s1_a_ff),
      .b_value    (s1_b_ff),
      .prod_value (prod_in)
   );

   bdp_add u_add (
      .x_value   (acc_op),
      .y_value   (s2_prod_ff),
      .sum_value (sum_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_ff <= bdp_pkg::POS_ZERO;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff && s2_last_ff;
         if (s2_valid_ff) begin
            sum_ff <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_a_ff <= req_a_value;
         s1_b_ff <= req_b_value;
         s1_bias_ff <= req_bias_value;
         s1_first_ff <= req_first_item;
         s1_last_ff <= req_last_item;
         s2_prod_ff <= prod_in;
         s2_bias_ff <= s1_bias_ff;
         s2_first_ff <= s1_first_ff;
         s2_last_ff <= s1_last_ff;
         rsp_sum_ff <= sum_in;
      end
   end

endmodule

// File: design/bdp_checker.sv
// Port-level checks for the BF16 dot-product engine and their binding.
`timescale 1ns / 1ps
module bdp_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_last_item,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_sum_value
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sum_value))
      else $error("result dropped or changed while stalled");

   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a held result");

   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last_item) ##1 !req_stall ##1 !req_stall |=> rsp_valid)
      else $error("last request produced no result");

endmodule

bind bf16_dot_product_fp32_accumulate_top bdp_port_checks u_bdp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_last_item (req_last_item),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_sum_value (rsp_sum_value)
);
